/* rtl/pbsa_pkg.sv */
// Package for the priority blend steering arbiter: widths, table depth, types.
// No dependencies.
package pbsa_pkg;
	localparam int NumPri = 16;
	localparam int PriW = 4;
	localparam int VelW = 32;
	localparam int WgtW = 16;
	localparam int AccW = 64;
	localparam int AccWgtW = 32;
	localparam int ThrW = 31;
	localparam logic [ThrW-1:0] ThrReset = 31'd66;

	typedef struct packed {
		logic [PriW-1:0] priority_req;
		logic signed [VelW-1:0] vel_x;
		logic signed [VelW-1:0] vel_y;
		logic [WgtW-1:0] weight;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic signed [VelW-1:0] out_x;
		logic signed [VelW-1:0] out_y;
		logic found;
		logic [PriW-1:0] winner;
	} out_item_t;

	// Product item handed from front to back
	typedef struct packed {
		logic [PriW-1:0] pri;
		logic signed [AccW-1:0] px;
		logic signed [AccW-1:0] py;
		logic [WgtW-1:0] w;
		logic last;
	} prod_t;
endpackage

/* rtl/pbsa_if.sv */
// Valid/ready channel interfaces for the arbiter.
// Depends on pbsa_pkg.
interface pbsa_in_if;
	logic valid;
	logic ready;
	pbsa_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pbsa_out_if;
	logic valid;
	logic ready;
	pbsa_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/pbsa_front.sv */
// Front: accepts items, forms weighted velocity products, feeds a 2-entry queue.
// Depends on pbsa_pkg, pbsa_if.
module pbsa_front (
	input logic clk,
	input logic arst_n,
	pbsa_in_if.sink in_ch,
	output logic q_valid,
	output pbsa_pkg::prod_t q_data,
	input logic q_ready
);
	localparam int AccW = pbsa_pkg::AccW;

	pbsa_pkg::prod_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	pbsa_pkg::prod_t p;
	logic push, pop;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rp_q];

	// Form products: 32x16 signed by unsigned
	always_comb begin
		p.pri = in_ch.data.priority_req;
		p.px = AccW'(in_ch.data.vel_x) * $signed({1'b0, in_ch.data.weight});
		p.py = AccW'(in_ch.data.vel_y) * $signed({1'b0, in_ch.data.weight});
		p.w = in_ch.data.weight;
		p.last = in_ch.data.last;
	end

	// Hold queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= p;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) (cnt_q == 2'd2) |-> !in_ch.ready)
		else $error("accept while full");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("push lost");
endmodule

/* rtl/pbsa_div.sv */
// Restoring signed 64/32 divider, one quotient bit per cycle, truncates toward zero.
// Depends on nothing.
module pbsa_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [63:0] num,
	input logic [31:0] den,
	output logic done,
	output logic signed [63:0] quo
);
	logic [63:0] n_q;
	logic [32:0] r_q;
	logic [31:0] d_q;
	logic neg_q, busy_q;
	logic [5:0] cnt_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {r_q[31:0], n_q[63]};
	assign trial = shifted - {1'b0, d_q};
	assign quo = neg_q ? -$signed(n_q) : $signed(n_q);

	// Step one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= 6'd0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num[63] ? 64'(-num) : num;
			neg_q <= num[63];
			d_q <= den;
			r_q <= 33'd0;
		end else if (busy_q) begin
			if (!trial[32]) begin
				r_q <= trial;
				n_q <= {n_q[62:0], 1'b1};
			end else begin
				r_q <= shifted;
				n_q <= {n_q[62:0], 1'b0};
			end
		end
	end
endmodule

/* rtl/pbsa_back.sv */
// Back: accumulates products into the priority table, scans on last, divides, emits.
// Depends on pbsa_pkg, pbsa_if, pbsa_div.
module pbsa_back (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input pbsa_pkg::prod_t q_data,
	output logic q_ready,
	input logic [pbsa_pkg::ThrW-1:0] thr,
	pbsa_out_if.source out_ch
);
	typedef enum logic [2:0] {ACC, SCAN, DIVX, DIVY, MAG, CMP, EMIT} st_t;
	st_t st_q;
	logic signed [63:0] acc_x_q [pbsa_pkg::NumPri];
	logic signed [63:0] acc_y_q [pbsa_pkg::NumPri];
	logic [31:0] acc_w_q [pbsa_pkg::NumPri];
	logic [pbsa_pkg::PriW-1:0] idx_q;
	logic signed [31:0] bx_q, by_q;
	logic [63:0] sx_q, sy_q, t2_q;
	pbsa_pkg::out_item_t res_q;
	logic dstart;
	logic signed [63:0] dnum;
	logic ddone;
	logic signed [63:0] dquo;
	logic signed [31:0] sat;
	logic [31:0] ax, ay;
	logic take;
	logic emit_go;

	pbsa_div u_div (.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum),
		.den(acc_w_q[idx_q]), .done(ddone), .quo(dquo));

	// Saturate quotient to 32 bits
	always_comb begin
		if (dquo > 64'sh7FFFFFFF) sat = 32'h7FFFFFFF;
		else if (dquo < -64'sh80000000) sat = 32'h80000000;
		else sat = dquo[31:0];
	end

	assign ax = bx_q[31] ? 32'(-bx_q) : bx_q;
	assign ay = by_q[31] ? 32'(-by_q) : by_q;
	assign q_ready = (st_q == ACC);
	assign take = q_valid && q_ready;
	assign emit_go = (st_q == EMIT) && (!out_ch.valid || out_ch.ready);
	assign dstart = ((st_q == SCAN) && (acc_w_q[idx_q] != 32'd0)) || ((st_q == DIVX) && ddone);
	assign dnum = (st_q == SCAN) ? acc_x_q[idx_q] : acc_y_q[idx_q];

	// Sequence accumulate, scan and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ACC;
			idx_q <= '0;
			out_ch.valid <= 1'b0;
			for (int i = 0; i < pbsa_pkg::NumPri; i++) begin
				acc_x_q[i] <= '0;
				acc_y_q[i] <= '0;
				acc_w_q[i] <= '0;
			end
		end else begin
			// Present a new result once the output register is free
			if (emit_go) out_ch.valid <= 1'b1;
			else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			unique case (st_q)
				ACC: if (take) begin
					acc_x_q[q_data.pri] <= acc_x_q[q_data.pri] + q_data.px;
					acc_y_q[q_data.pri] <= acc_y_q[q_data.pri] + q_data.py;
					acc_w_q[q_data.pri] <= acc_w_q[q_data.pri] + 32'(q_data.w);
					if (q_data.last) begin
						st_q <= SCAN;
						idx_q <= '0;
						t2_q <= 64'(thr) * 64'(thr);
					end
				end
				SCAN: begin
					if (acc_w_q[idx_q] != 32'd0) st_q <= DIVX;
					else if (idx_q == pbsa_pkg::PriW'(pbsa_pkg::NumPri - 1)) begin
						res_q <= '0;
						st_q <= EMIT;
					end else idx_q <= idx_q + 1'b1;
				end
				DIVX: if (ddone) begin
					bx_q <= sat;
					st_q <= DIVY;
				end
				DIVY: if (ddone) begin
					by_q <= sat;
					st_q <= MAG;
				end
				MAG: begin
					sx_q <= 64'(ax) * 64'(ax);
					sy_q <= 64'(ay) * 64'(ay);
					st_q <= CMP;
				end
				CMP: begin
					if ({1'b0, sx_q} + {1'b0, sy_q} > {1'b0, t2_q}) begin
						res_q.out_x <= bx_q;
						res_q.out_y <= by_q;
						res_q.found <= 1'b1;
						res_q.winner <= idx_q;
						st_q <= EMIT;
					end else if (idx_q == pbsa_pkg::PriW'(pbsa_pkg::NumPri - 1)) begin
						res_q <= '0;
						st_q <= EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
						st_q <= SCAN;
					end
				end
				EMIT: if (emit_go) begin
					out_ch.data <= res_q;
					for (int i = 0; i < pbsa_pkg::NumPri; i++) begin
						acc_x_q[i] <= '0;
						acc_y_q[i] <= '0;
						acc_w_q[i] <= '0;
					end
					st_q <= ACC;
				end
				default: st_q <= ACC;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) (st_q != ACC) |-> !q_ready)
		else $error("accepted during evaluation");
	assert property (@(posedge clk) disable iff (!arst_n) (st_q == EMIT) |=> out_ch.valid)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.data.found) |-> (out_ch.data.winner == '0))
		else $error("winner set without found");
endmodule

/* rtl/priority_blend_steering_arbiter.sv */
// Priority blend steering arbiter: accepts weighted velocity contributions at one item per
// cycle through a 2-entry queue and accumulates them per priority group. An item with last
// stops accumulation for the scan: an empty group is skipped, a group with weight is
// divided twice in the shared serial divider, then squared and compared, and the result
// is emitted when the scan ends. The input keeps accepting until the queue is full. The
// result waits in its own register, so an untaken result holds accumulation only when the
// next scan ends first.
// Depends on pbsa_pkg, pbsa_if, pbsa_front, pbsa_back.
module priority_blend_steering_arbiter (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [pbsa_pkg::ThrW-1:0] cfg_wdata,
	pbsa_in_if.sink in_ch,
	pbsa_out_if.source out_ch
);
	logic [pbsa_pkg::ThrW-1:0] thr_q;
	logic q_valid, q_ready;
	pbsa_pkg::prod_t q_data;

	// Hold the threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= pbsa_pkg::ThrReset;
		else if (cfg_we) thr_q <= cfg_wdata;
	end

	pbsa_front u_front (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .q_valid(q_valid),
		.q_data(q_data), .q_ready(q_ready));
	pbsa_back u_back (.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_data(q_data),
		.q_ready(q_ready), .thr(thr_q), .out_ch(out_ch));
endmodule
